### rtl/stitch_linear_blend_pixel_top_defines.svh
// Assertion macros used by the checker file of the stitching blender.
// The macros expect a signal named clk, and all but SLBP_ASSERT_RESET also rst_n, in the scope where used.
`ifndef STITCH_LINEAR_BLEND_PIXEL_TOP_DEFINES_SVH
`define STITCH_LINEAR_BLEND_PIXEL_TOP_DEFINES_SVH

// Antecedent in one cycle, consequent in the next, ignored while in reset.
`define SLBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slbp: next-cycle property failed");

// Antecedent and consequent in the same cycle, ignored while in reset.
`define SLBP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slbp: same-cycle property failed");

// Checked also while reset is applied.
`define SLBP_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("slbp: reset property failed");

`endif

### rtl/slbp_pkg.sv
package slbp_pkg;

  localparam int COORD_BITS      = 13;
  localparam int CMP_BITS        = COORD_BITS + 2;
  localparam int REGION_BITS     = 2;
  localparam int CFG_ADDR_BITS   = 5;
  localparam int CFG_DATA_BITS   = 32;
  localparam int DEF_PIXEL_BITS  = 8;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_WIDTH_A       = 3'd0;
  localparam logic [2:0] REG_HEIGHT_A      = 3'd1;
  localparam logic [2:0] REG_HEIGHT_B      = 3'd2;
  localparam logic [2:0] REG_OVERLAP_WIDTH = 3'd3;
  localparam logic [2:0] REG_SHIFT_ROWS    = 3'd4;

  localparam logic [COORD_BITS-1:0] RST_WIDTH_A       = 13'd640;
  localparam logic [COORD_BITS-1:0] RST_HEIGHT_A      = 13'd480;
  localparam logic [COORD_BITS-1:0] RST_HEIGHT_B      = 13'd480;
  localparam logic [COORD_BITS-1:0] RST_OVERLAP_WIDTH = 13'd0;
  localparam logic [COORD_BITS-1:0] RST_SHIFT_ROWS    = 13'd0;

  typedef enum logic [REGION_BITS-1:0] {
    REGION_BLEND = 2'd0,
    REGION_A     = 2'd1,
    REGION_B     = 2'd2,
    REGION_BLACK = 2'd3
  } region_t;

  typedef struct packed {
    logic        [COORD_BITS-1:0] width_a;
    logic        [COORD_BITS-1:0] height_a;
    logic        [COORD_BITS-1:0] height_b;
    logic        [COORD_BITS-1:0] overlap_width;
    logic signed [COORD_BITS-1:0] shift_rows;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Bits of one queue entry: region, two blend weights, six channels.
  function automatic int entry_bits(input int pix_bits);
    return REGION_BITS + 2 * COORD_BITS + 6 * pix_bits;
  endfunction

endpackage

### rtl/slbp_front.sv
module slbp_front
  import slbp_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  cfg_t                              cfg,
  input  logic [COORD_BITS-1:0]             pos_x,
  input  logic [COORD_BITS-1:0]             pos_y,
  input  logic [2:0][PIXEL_BITS-1:0]        a_pix,
  input  logic [2:0][PIXEL_BITS-1:0]        b_pix,
  output logic [entry_bits(PIXEL_BITS)-1:0] entry
);

  logic signed [CMP_BITS-1:0] xs, ys, wa_s, dx_s, s_s, dy_s, ndy_s, ha_s, hb_s, hb_end_s;
  logic                       dy_pos, x_in_a, x_ge_s;
  logic [COORD_BITS-1:0]      weight_a, weight_b;
  region_t                    region;

  assign xs       = signed'(CMP_BITS'(pos_x));
  assign ys       = signed'(CMP_BITS'(pos_y));
  assign wa_s     = signed'(CMP_BITS'(cfg.width_a));
  assign dx_s     = signed'(CMP_BITS'(cfg.overlap_width));
  assign ha_s     = signed'(CMP_BITS'(cfg.height_a));
  assign hb_s     = signed'(CMP_BITS'(cfg.height_b));
  assign dy_s     = CMP_BITS'(cfg.shift_rows);
  assign s_s      = wa_s - dx_s;
  assign ndy_s    = -dy_s;
  assign hb_end_s = ndy_s + hb_s;

  assign dy_pos = (dy_s > 0);
  assign x_in_a = (xs < wa_s);
  assign x_ge_s = (xs >= s_s);

  always_comb begin
    region = REGION_BLACK;
    if (!dy_pos) begin
      if (x_in_a && (ys < ha_s)) begin
        region = (x_ge_s && (ys >= ndy_s)) ? REGION_BLEND : REGION_A;
      end else if (x_ge_s && (ys >= ndy_s) && (ys < hb_end_s)) begin
        region = REGION_B;
      end
    end else begin
      if (x_in_a && (ys >= dy_s)) begin
        region = (x_ge_s && (ys < hb_s)) ? REGION_BLEND : REGION_A;
      end else if (x_ge_s && (ys < hb_s)) begin
        region = REGION_B;
      end
    end
  end

  // Both weights lie in 0 .. overlap_width inside the overlap, so modular
  // arithmetic at the coordinate width is exact there.
  assign weight_a = cfg.width_a - pos_x;
  assign weight_b = pos_x - cfg.width_a + cfg.overlap_width;

  assign entry = {region, weight_a, weight_b, a_pix, b_pix};

endmodule

### rtl/slbp_queue.sv
module slbp_queue
  import slbp_pkg::*;
#(
  parameter int WIDTH = DEF_PIXEL_BITS,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output q_status_t        status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign cnt_nxt    = cnt_r + CW'(push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data      = slot_r[rd_ptr_r];
  assign status.full  = (cnt_r == CW'(DEPTH));
  assign status.empty = (cnt_r == '0);

endmodule

### rtl/slbp_back.sv
module slbp_back
  import slbp_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [COORD_BITS-1:0]             overlap_width,
  input  logic [entry_bits(PIXEL_BITS)-1:0] entry,
  input  logic                              entry_valid,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0][PIXEL_BITS-1:0]        out_pix,
  output region_t                           out_region
);

  localparam int NW   = PIXEL_BITS + COORD_BITS;
  localparam int LAST = PIXEL_BITS + 1;

  logic [REGION_BITS-1:0]      e_region_bits;
  region_t                     e_region;
  logic [COORD_BITS-1:0]       e_wa, e_wb;
  logic [2:0][PIXEL_BITS-1:0]  e_a, e_b, e_byp;

  logic                        vld_r  [0:LAST];
  region_t                     reg_r  [0:LAST];
  logic [2:0][PIXEL_BITS-1:0]  byp_r  [0:LAST];
  logic [2:0][NW-1:0]          pa_r, pb_r;
  logic [2:0][NW-1:0]          rem_r  [1:LAST];
  logic [2:0][PIXEL_BITS-1:0]  q_r    [1:LAST];
  logic [2:0][NW-1:0]          rem_nxt[2:LAST];
  logic [2:0][PIXEL_BITS-1:0]  q_nxt  [2:LAST];
  logic                        adv;

  assign {e_region_bits, e_wa, e_wb, e_a, e_b} = entry;
  assign e_region = region_t'(e_region_bits);

  always_comb begin
    case (e_region)
      REGION_A: e_byp = e_a;
      REGION_B: e_byp = e_b;
      default:  e_byp = '0;
    endcase
  end

  assign adv = !vld_r[LAST] || out_ready;
  assign pop = adv && entry_valid;

  // One restoring step per quotient bit, most significant bit first.
  always_comb begin
    logic [NW-1:0] dsh;
    logic          ge;
    for (int i = 0; i < PIXEL_BITS; i++) begin
      dsh = NW'(overlap_width) << (PIXEL_BITS - 1 - i);
      for (int c = 0; c < 3; c++) begin
        ge = (rem_r[i+1][c] >= dsh);
        rem_nxt[i+2][c] = ge ? rem_r[i+1][c] - dsh : rem_r[i+1][c];
        q_nxt[i+2][c]   = (q_r[i+1][c] << 1) | PIXEL_BITS'(ge);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= LAST; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= entry_valid;
      for (int j = 1; j <= LAST; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      reg_r[0] <= e_region;
      byp_r[0] <= e_byp;
      for (int c = 0; c < 3; c++) begin
        pa_r[c]     <= NW'(e_a[c]) * NW'(e_wa);
        pb_r[c]     <= NW'(e_b[c]) * NW'(e_wb);
        rem_r[1][c] <= pa_r[c] + pb_r[c];
      end
      q_r[1] <= '0;
      for (int j = 1; j <= LAST; j++) begin
        reg_r[j] <= reg_r[j-1];
        byp_r[j] <= byp_r[j-1];
      end
      for (int j = 2; j <= LAST; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  assign out_valid  = vld_r[LAST];
  assign out_region = reg_r[LAST];
  assign out_pix    = (reg_r[LAST] == REGION_BLEND) ? q_r[LAST] : byp_r[LAST];

endmodule

### rtl/stitch_linear_blend_pixel_top.sv
// Channel   Direction  Handshake             Contents of one beat
// in_       input      in_valid / in_ready   canvas column and row, RGB of A and of B
// out_      output     out_valid / out_ready stitched RGB pixel and region code
// APB       config     psel / penable        five 13-bit registers at byte offsets 0..16
//
// One beat is accepted per clock while the queue has room, and one result leaves per clock when out_ready stays high.
// Each accepted beat passes through the queue, the product and sum registers and the blend
// divider, which has one restoring stage per quotient bit.
// rst_n is synchronous and active low; it empties the queue and the pipeline and loads
// the register defaults. A stalled output freezes the whole blend pipeline; the queue
// between classifier and pipeline keeps accepting beats until it is full.
module stitch_linear_blend_pixel_top
  import slbp_pkg::*;
#(
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COORD_BITS-1:0]    in_pos_x,
  input  logic [COORD_BITS-1:0]    in_pos_y,
  input  logic [PIXEL_BITS-1:0]    in_a_red,
  input  logic [PIXEL_BITS-1:0]    in_a_green,
  input  logic [PIXEL_BITS-1:0]    in_a_blue,
  input  logic [PIXEL_BITS-1:0]    in_b_red,
  input  logic [PIXEL_BITS-1:0]    in_b_green,
  input  logic [PIXEL_BITS-1:0]    in_b_blue,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PIXEL_BITS-1:0]    out_red,
  output logic [PIXEL_BITS-1:0]    out_green,
  output logic [PIXEL_BITS-1:0]    out_blue,
  output logic [REGION_BITS-1:0]   out_region,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int EW = entry_bits(PIXEL_BITS);

  // Configuration registers. They are to be written only while the block is idle, which the block
  // itself does not enforce, so the classifier and the divider read them directly.
  cfg_t                       cfg_r;
  logic                       cfg_we;
  logic [2:0]                 cfg_idx;
  logic [COORD_BITS-1:0]      cfg_wdata;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[CFG_ADDR_BITS-1:2];
  assign cfg_wdata = pwdata[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_a       <= RST_WIDTH_A;
      cfg_r.height_a      <= RST_HEIGHT_A;
      cfg_r.height_b      <= RST_HEIGHT_B;
      cfg_r.overlap_width <= RST_OVERLAP_WIDTH;
      cfg_r.shift_rows    <= signed'(RST_SHIFT_ROWS);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH_A:       cfg_r.width_a       <= cfg_wdata;
        REG_HEIGHT_A:      cfg_r.height_a      <= cfg_wdata;
        REG_HEIGHT_B:      cfg_r.height_b      <= cfg_wdata;
        REG_OVERLAP_WIDTH: cfg_r.overlap_width <= cfg_wdata;
        REG_SHIFT_ROWS:    cfg_r.shift_rows    <= signed'(cfg_wdata);
        default:           ;
      endcase
    end
  end

  // Readback; the vertical shift is returned sign-extended.
  always_comb begin
    case (cfg_idx)
      REG_WIDTH_A:       prdata = CFG_DATA_BITS'(cfg_r.width_a);
      REG_HEIGHT_A:      prdata = CFG_DATA_BITS'(cfg_r.height_a);
      REG_HEIGHT_B:      prdata = CFG_DATA_BITS'(cfg_r.height_b);
      REG_OVERLAP_WIDTH: prdata = CFG_DATA_BITS'(cfg_r.overlap_width);
      REG_SHIFT_ROWS:    prdata = CFG_DATA_BITS'(cfg_r.shift_rows);
      default:           prdata = '0;
    endcase
  end

  // Front: classify each beat and compute the two blend weights.
  logic [2:0][PIXEL_BITS-1:0] a_pix, b_pix, res_pix;
  logic [EW-1:0]              front_entry, head_entry;
  q_status_t                  q_status;
  logic                       push, pop;
  region_t                    res_region;

  assign a_pix = {in_a_red, in_a_green, in_a_blue};
  assign b_pix = {in_b_red, in_b_green, in_b_blue};

  slbp_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .cfg   (cfg_r),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .a_pix (a_pix),
    .b_pix (b_pix),
    .entry (front_entry)
  );

  // The queue decouples the classifier from the blend pipeline, so in_ready
  // depends only on the queue fill and never on out_ready.
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  slbp_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_entry),
    .pop     (pop),
    .rd_data (head_entry),
    .status  (q_status)
  );

  // Back: weighted sums, then a pipelined divide by the overlap width.
  slbp_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .overlap_width (cfg_r.overlap_width),
    .entry         (head_entry),
    .entry_valid   (!q_status.empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pix       (res_pix),
    .out_region    (res_region)
  );

  assign out_red    = res_pix[2];
  assign out_green  = res_pix[1];
  assign out_blue   = res_pix[0];
  assign out_region = res_region;

endmodule

### rtl/slbp_checker.sv
`include "stitch_linear_blend_pixel_top_defines.svh"

module slbp_checker
  import slbp_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [PIXEL_BITS-1:0]    out_red,
  input logic [PIXEL_BITS-1:0]    out_green,
  input logic [PIXEL_BITS-1:0]    out_blue,
  input logic [REGION_BITS-1:0]   out_region,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [CFG_ADDR_BITS-1:0] paddr,
  input logic [CFG_DATA_BITS-1:0] pwdata,
  input logic [CFG_DATA_BITS-1:0] prdata,
  input logic                     pready
);

  logic [3*PIXEL_BITS-1:0]             out_rgb;
  logic [3*PIXEL_BITS+REGION_BITS-1:0] out_beat;
  logic                                width_sel;
  logic                                width_wr;
  logic [COORD_BITS-1:0]               wr_low;
  logic [COORD_BITS-1:0]               rd_low;

  assign out_rgb   = {out_red, out_green, out_blue};
  assign out_beat  = {out_rgb, out_region};
  assign width_sel = (paddr[CFG_ADDR_BITS-1:2] == REG_WIDTH_A);
  assign width_wr  = psel && penable && pwrite && pready && width_sel;
  assign wr_low    = pwdata[COORD_BITS-1:0];
  assign rd_low    = prdata[COORD_BITS-1:0];

  // A result that is not taken stays on the port unchanged.
  `SLBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

  // Black fill carries no color.
  `SLBP_ASSERT_SAME(a_black_zero, out_valid && out_region == REGION_BLACK, out_rgb == '0)

  // Reset leaves the block empty and ready for a beat.
  `SLBP_ASSERT_RESET(a_reset_idle, !rst_n, in_ready && !out_valid)

  // A written image width reads back in the following cycle.
  `SLBP_ASSERT_NEXT(a_width_readback, width_wr, !width_sel || rd_low == $past(wr_low))

endmodule

bind stitch_linear_blend_pixel_top slbp_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_slbp_checker (.*);

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slbp_pkg::*;

  // Allowance for the blend divider pipeline, used in the final drain wait.
  localparam int PIPE_LATENCY = DEF_PIXEL_BITS + 2;
  // Watchdog limit, chosen as a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_SETS  = 12;
  localparam int SET_BEATS    = 148;

  // One input beat: a canvas coordinate plus the pixels of both images there.
  typedef struct packed {
    logic [COORD_BITS-1:0]     pos_x;
    logic [COORD_BITS-1:0]     pos_y;
    logic [DEF_PIXEL_BITS-1:0] a_red;
    logic [DEF_PIXEL_BITS-1:0] a_green;
    logic [DEF_PIXEL_BITS-1:0] a_blue;
    logic [DEF_PIXEL_BITS-1:0] b_red;
    logic [DEF_PIXEL_BITS-1:0] b_green;
    logic [DEF_PIXEL_BITS-1:0] b_blue;
  } pixel_beat_t;

  // One stitched output pixel with the region it was classified into.
  typedef struct packed {
    logic [DEF_PIXEL_BITS-1:0] red;
    logic [DEF_PIXEL_BITS-1:0] green;
    logic [DEF_PIXEL_BITS-1:0] blue;
    region_t                   rgn;
  } stitched_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [COORD_BITS-1:0]     in_pos_x = '0;
  logic [COORD_BITS-1:0]     in_pos_y = '0;
  logic [DEF_PIXEL_BITS-1:0] in_a_red = '0;
  logic [DEF_PIXEL_BITS-1:0] in_a_green = '0;
  logic [DEF_PIXEL_BITS-1:0] in_a_blue = '0;
  logic [DEF_PIXEL_BITS-1:0] in_b_red = '0;
  logic [DEF_PIXEL_BITS-1:0] in_b_green = '0;
  logic [DEF_PIXEL_BITS-1:0] in_b_blue = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [DEF_PIXEL_BITS-1:0] out_red;
  logic [DEF_PIXEL_BITS-1:0] out_green;
  logic [DEF_PIXEL_BITS-1:0] out_blue;
  logic [REGION_BITS-1:0]    out_region;

  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  paddr = '0;
  logic [CFG_DATA_BITS-1:0]  pwdata = '0;
  logic [CFG_DATA_BITS-1:0]  prdata;
  logic                      pready;

  // Shadow of the block's registers, kept in step with every write we issue.
  cfg_t canvas_cfg = '{RST_WIDTH_A, RST_HEIGHT_A, RST_HEIGHT_B, RST_OVERLAP_WIDTH,
                       RST_SHIFT_ROWS};
  logic [2:0] canvas_regs [5] = '{REG_WIDTH_A, REG_HEIGHT_A, REG_HEIGHT_B,
                                  REG_OVERLAP_WIDTH, REG_SHIFT_ROWS};

  // Pixels predicted for accepted beats, oldest first.
  stitched_px_t pixels_due[$];

  int send_idle_pct = 20;
  int recv_idle_pct = 57;
  int hold_left = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int canvases_used = 0;
  int cycle_count = 0;
  int region_seen [4] = '{0, 0, 0, 0};

  stitch_linear_blend_pixel_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_a_red   (in_a_red),
    .in_a_green (in_a_green),
    .in_a_blue  (in_a_blue),
    .in_b_red   (in_b_red),
    .in_b_green (in_b_green),
    .in_b_blue  (in_b_blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_region (out_region),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 2 ns clock, one nanosecond high and one low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog. A hung handshake ends the run here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: run exceeded %0d cycles with %0d pixels outstanding", $time,
               CYCLE_LIMIT, pixels_due.size());
      $display("stitch_linear_blend_pixel_top regression: fail");
      $finish;
    end
  end

  // Result receiver. A hold-off request from a test parks out_ready low while
  // hold_left counts down; otherwise ready drops at random at the current idle rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Result checker: every beat leaving the block is matched against the oldest
  // prediction. A beat with nothing pending is itself a failure.
  always @(posedge clk) begin : check_results
    stitched_px_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected pixel, expected none, actual rgb %0d %0d %0d region %0d",
                 $time, out_red, out_green, out_blue, out_region);
      end else begin
        want = pixels_due.pop_front();
        region_seen[want.rgn]++;
        compare_field("region", want.rgn, out_region);
        compare_field("red", want.red, out_red);
        compare_field("green", want.green, out_green);
        compare_field("blue", want.blue, out_blue);
      end
    end
  end

  // Predicts the stitched pixel from the current register shadow. All tests run
  // on the raw register values, so negative seam positions and overlaps wider
  // than image A fall out of plain signed arithmetic.
  function automatic stitched_px_t predict_pixel(input pixel_beat_t px);
    int x, y, seam, dy, wid_a, hgt_a, hgt_b, ovl, wa, wb;
    int a_ch [3];
    int b_ch [3];
    int out_ch [3];
    region_t rgn;
    stitched_px_t res;
    x = px.pos_x;
    y = px.pos_y;
    wid_a = canvas_cfg.width_a;
    hgt_a = canvas_cfg.height_a;
    hgt_b = canvas_cfg.height_b;
    ovl = canvas_cfg.overlap_width;
    dy = $signed(canvas_cfg.shift_rows);
    seam = wid_a - ovl;
    a_ch = '{px.a_red, px.a_green, px.a_blue};
    b_ch = '{px.b_red, px.b_green, px.b_blue};
    // B sits above A when the shift is zero or negative, below it otherwise.
    if (dy <= 0) begin
      if (x < wid_a && y < hgt_a) begin
        rgn = (x >= seam && y >= -dy) ? REGION_BLEND : REGION_A;
      end else if (x >= seam && y >= -dy && y < hgt_b - dy) begin
        rgn = REGION_B;
      end else begin
        rgn = REGION_BLACK;
      end
    end else begin
      if (x < wid_a && y >= dy) begin
        rgn = (x >= seam && y < hgt_b) ? REGION_BLEND : REGION_A;
      end else if (x >= seam && y < hgt_b) begin
        rgn = REGION_B;
      end else begin
        rgn = REGION_BLACK;
      end
    end
    // The blend weights sum to the overlap width, so the quotient always fits.
    wa = wid_a - x;
    wb = x - seam;
    for (int ch = 0; ch < 3; ch++) begin
      case (rgn)
        REGION_BLEND: out_ch[ch] = (a_ch[ch] * wa + b_ch[ch] * wb) / ovl;
        REGION_A:     out_ch[ch] = a_ch[ch];
        REGION_B:     out_ch[ch] = b_ch[ch];
        default:      out_ch[ch] = 0;
      endcase
    end
    res.red = out_ch[0][DEF_PIXEL_BITS-1:0];
    res.green = out_ch[1][DEF_PIXEL_BITS-1:0];
    res.blue = out_ch[2][DEF_PIXEL_BITS-1:0];
    res.rgn = rgn;
    return res;
  endfunction

  function automatic logic [COORD_BITS-1:0] cfg_field(input cfg_t c, input logic [2:0] idx);
    case (idx)
      REG_WIDTH_A:       return c.width_a;
      REG_HEIGHT_A:      return c.height_a;
      REG_HEIGHT_B:      return c.height_b;
      REG_OVERLAP_WIDTH: return c.overlap_width;
      REG_SHIFT_ROWS:    return c.shift_rows;
      default:           return '0;
    endcase
  endfunction

  // One APB write: setup cycle, then access cycle until pready. The bus is then left
  // idle so back-to-back calls never drive psel twice in one step.
  task automatic write_reg(input logic [2:0] idx, input logic [COORD_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(CFG_DATA_BITS-COORD_BITS){val[COORD_BITS-1]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH_A:       canvas_cfg.width_a = val;
      REG_HEIGHT_A:      canvas_cfg.height_a = val;
      REG_HEIGHT_B:      canvas_cfg.height_b = val;
      REG_OVERLAP_WIDTH: canvas_cfg.overlap_width = val;
      REG_SHIFT_ROWS:    canvas_cfg.shift_rows = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reads every register back and compares its low 13 bits with the shadow.
  task automatic verify_registers();
    logic [CFG_DATA_BITS-1:0] got;
    foreach (canvas_regs[i]) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {canvas_regs[i], 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got[COORD_BITS-1:0] !== cfg_field(canvas_cfg, canvas_regs[i])) begin
        mismatches++;
        $display("%0t ns: register %0d readback mismatch, expected %0d, actual %0d", $time,
                 canvas_regs[i], cfg_field(canvas_cfg, canvas_regs[i]), got[COORD_BITS-1:0]);
      end
      @(posedge clk);
    end
  endtask

  task automatic apply_canvas(input cfg_t c);
    write_reg(REG_WIDTH_A, c.width_a);
    write_reg(REG_HEIGHT_A, c.height_a);
    write_reg(REG_HEIGHT_B, c.height_b);
    write_reg(REG_OVERLAP_WIDTH, c.overlap_width);
    write_reg(REG_SHIFT_ROWS, c.shift_rows);
    canvases_used++;
  endtask

  // Offers one beat, with a random idle gap in front of it, and holds it until
  // the block takes it. The prediction is queued at the accepting edge.
  task automatic send_pixel(input pixel_beat_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pos_x   <= px.pos_x;
    in_pos_y   <= px.pos_y;
    in_a_red   <= px.a_red;
    in_a_green <= px.a_green;
    in_a_blue  <= px.a_blue;
    in_b_red   <= px.b_red;
    in_b_green <= px.b_green;
    in_b_blue  <= px.b_blue;
    do @(posedge clk); while (!in_ready);
    pixels_due.push_back(predict_pixel(px));
    beats_sent++;
  endtask

  task automatic send_at(input int x, input int y, input logic [23:0] a_rgb,
                         input logic [23:0] b_rgb);
    send_pixel('{COORD_BITS'(x), COORD_BITS'(y), a_rgb[23:16], a_rgb[15:8], a_rgb[7:0],
                 b_rgb[23:16], b_rgb[15:8], b_rgb[7:0]});
  endtask

  // Drops valid and waits until every predicted pixel has come out. Always waits
  // for a clock edge, so valid is never lowered and raised in one step.
  task automatic settle_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_due.size() != 0);
  endtask

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > 8191) return 13'd8191;
    return COORD_BITS'(v);
  endfunction

  function automatic logic [DEF_PIXEL_BITS-1:0] random_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return DEF_PIXEL_BITS'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] random_dim();
    case ($urandom_range(9))
      0:       return 13'd1;
      1:       return 13'd4096;
      default: return COORD_BITS'($urandom_range(700, 8));
    endcase
  endfunction

  // Coordinates are steered toward the seam, the edge of A and every row boundary so that
  // all region tests flip often; a quarter of the columns and an eighth of the rows are uniform.
  function automatic pixel_beat_t random_beat();
    pixel_beat_t px;
    int seam, dy, wid_a, jitter;
    wid_a = canvas_cfg.width_a;
    seam = wid_a - int'(canvas_cfg.overlap_width);
    dy = $signed(canvas_cfg.shift_rows);
    jitter = int'($urandom_range(8)) - 4;
    case ($urandom_range(3))
      0:       px.pos_x = COORD_BITS'($urandom_range(8191));
      1:       px.pos_x = clamp_coord(seam + jitter);
      2:       px.pos_x = clamp_coord(wid_a + jitter);
      default: px.pos_x = clamp_coord(seam + int'($urandom_range(canvas_cfg.overlap_width)));
    endcase
    jitter = int'($urandom_range(8)) - 4;
    case ($urandom_range(7))
      0:       px.pos_y = COORD_BITS'($urandom_range(8191));
      1:       px.pos_y = clamp_coord(-dy + jitter);
      2:       px.pos_y = clamp_coord(int'(canvas_cfg.height_b) - dy + jitter);
      3:       px.pos_y = clamp_coord(int'(canvas_cfg.height_a) + jitter);
      4:       px.pos_y = clamp_coord(dy + jitter);
      5:       px.pos_y = clamp_coord(int'(canvas_cfg.height_b) + jitter);
      default: px.pos_y = COORD_BITS'($urandom_range(700));
    endcase
    px.a_red = random_channel();
    px.a_green = random_channel();
    px.a_blue = random_channel();
    px.b_red = random_channel();
    px.b_green = random_channel();
    px.b_blue = random_channel();
    return px;
  endfunction

  // The first few sets pin the register extremes; the rest are random, with an
  // occasional overlap wider than image A so the seam goes negative.
  function automatic cfg_t pick_canvas(input int set_no);
    cfg_t c;
    case (set_no)
      0: c = '{13'd4096, 13'd4096, 13'd4096, 13'd4096, -13'sd4095};
      1: c = '{13'd1, 13'd1, 13'd1, 13'd1, 13'sd4095};
      2: c = '{13'd4096, 13'd1, 13'd4096, 13'd0, 13'sd0};
      default: begin
        c.width_a = random_dim();
        c.height_a = random_dim();
        c.height_b = random_dim();
        case ($urandom_range(9))
          0:       c.overlap_width = '0;
          1:       c.overlap_width = c.width_a;
          2:       c.overlap_width = c.width_a + COORD_BITS'($urandom_range(200, 1));
          default: c.overlap_width = COORD_BITS'($urandom_range(c.width_a, 1));
        endcase
        case ($urandom_range(9))
          0:       c.shift_rows = -13'sd4095;
          1:       c.shift_rows = 13'sd4095;
          2:       c.shift_rows = '0;
          default: c.shift_rows = COORD_BITS'(int'($urandom_range(600)) - 300);
        endcase
      end
    endcase
    return c;
  endfunction

  // Reset layout: no overlap and no shift, so only A, B and black appear.
  task automatic test_default_layout();
    send_at(0, 0, 24'hffffff, 24'h000000);
    send_at(639, 479, 24'h0180ff, 24'hfe7f00);
    send_at(640, 0, 24'h123456, 24'h89abcd);
    send_at(640, 480, 24'hffffff, 24'hffffff);
    send_at(8191, 8191, 24'hffffff, 24'hffffff);
    send_at(0, 480, 24'h555555, 24'haaaaaa);
    settle_pixels();
  endtask

  // Readback of the reset values, then of a written set that includes a
  // negative shift.
  task automatic test_register_access();
    verify_registers();
    apply_canvas('{13'd1234, 13'd777, 13'd4095, 13'd321, -13'sd1234});
    verify_registers();
  endtask

  task automatic test_directed_regions();
    // B above A with a short B, so blended rows run past B's last row.
    apply_canvas('{13'd100, 13'd50, 13'd20, 13'd20, -13'sd5});
    send_at(80, 5, 24'hffffff, 24'h000000);
    send_at(99, 49, 24'h123456, 24'habcdef);
    send_at(79, 10, 24'h10203f, 24'hffffff);
    send_at(90, 2, 24'hff00ff, 24'h00ff00);
    send_at(100, 5, 24'h000000, 24'hfedcba);
    send_at(100, 24, 24'h000000, 24'h7f8081);
    send_at(100, 25, 24'hffffff, 24'hffffff);
    send_at(5, 60, 24'hffffff, 24'hffffff);
    settle_pixels();
    // Largest images, one-column overlap so the divisor is one, B far below.
    apply_canvas('{13'd4096, 13'd4096, 13'd4096, 13'd1, 13'sd4095});
    send_at(4095, 4095, 24'hffffff, 24'h000000);
    send_at(4094, 4095, 24'hc3c3c3, 24'h3c3c3c);
    send_at(4095, 4094, 24'h000000, 24'hffffff);
    send_at(8191, 0, 24'h0f0f0f, 24'hf0f0f0);
    send_at(0, 0, 24'hffffff, 24'hffffff);
    settle_pixels();
    // Overlap much wider than A: the seam lies left of column zero.
    apply_canvas('{13'd3, 13'd2, 13'd1, 13'd4096, -13'sd1});
    send_at(0, 1, 24'hffffff, 24'h000000);
    send_at(2, 1, 24'h000000, 24'hffffff);
    send_at(0, 0, 24'h808080, 24'h010101);
    send_at(3, 1, 24'h808080, 24'h010101);
    send_at(3, 2, 24'h808080, 24'h010101);
    settle_pixels();
  endtask

  // The receiver refuses results for a long stretch while the sender keeps
  // offering, so the queue and pipeline fill and in_ready must drop.
  task automatic test_output_backpressure();
    apply_canvas('{13'd64, 13'd48, 13'd48, 13'd16, 13'sd3});
    send_idle_pct = 0;
    hold_left = 300;
    repeat (40) send_pixel(random_beat());
    settle_pixels();
  endtask

  // Short bursts, each followed by a full pause until every result is back.
  task automatic test_sender_pause();
    apply_canvas('{13'd200, 13'd120, 13'd90, 13'd37, -13'sd11});
    send_idle_pct = 20;
    recv_idle_pct = 57;
    repeat (6) begin
      repeat (5) send_pixel(random_beat());
      settle_pixels();
    end
  endtask

  // Random beats over many canvas settings. The first third idles the sender
  // lightly and the receiver heavily, the second swaps them, the last runs flat out.
  task automatic test_random_canvases();
    for (int set_no = 0; set_no < RANDOM_SETS; set_no++) begin
      case (set_no * 3 / RANDOM_SETS)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      apply_canvas(pick_canvas(set_no));
      repeat (SET_BEATS) send_pixel(random_beat());
      settle_pixels();
    end
  endtask

  // Test sequence. Reset is applied once at the start; every register write
  // below happens with nothing in flight.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_layout();
    test_register_access();
    test_directed_regions();
    test_output_backpressure();
    test_sender_pause();
    test_random_canvases();
    settle_pixels();
    // Let any stray result surface before the verdict.
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    $display("Checked %0d beats over %0d canvas settings: %0d blended, %0d A-only, %0d B-only,",
             beats_sent, canvases_used, region_seen[REGION_BLEND], region_seen[REGION_A],
             region_seen[REGION_B]);
    $display("%0d black; register readback, output hold-off and sender pauses included.",
             region_seen[REGION_BLACK]);
    if (mismatches == 0) begin
      $display("stitch_linear_blend_pixel_top regression: pass");
    end else begin
      $display("stitch_linear_blend_pixel_top regression: fail");
    end
    $finish;
  end

endmodule
